>>> rtl/rwu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RPROP weight update unit - shared package
// Field widths, operation and result codes, register indexes, reset values
// and the per-entry adaptation state record.
// ----------------------------------------------------------------------------
package rwu_pkg;

   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned STEP_W     = 26;
   localparam int unsigned IDX_W      = 10;
   localparam int unsigned ETA_W      = 16;
   localparam int unsigned ETA_M_W    = 15;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 26;
   localparam int unsigned FRAC_SHIFT = 14;
   localparam int unsigned PROD_W     = STEP_W + ETA_W;
   localparam int unsigned SCALED_W   = PROD_W + 1 - FRAC_SHIFT;
   localparam int unsigned WIDE_W     = VALUE_W + 2;

   localparam logic [PROD_W:0] ROUND_ADD = (PROD_W + 1)'(8192);

   localparam logic [ETA_W-1:0]   ETA_PLUS_RST     = 16'd19661;
   localparam logic [ETA_M_W-1:0] ETA_MINUS_RST    = 15'd8192;
   localparam logic [STEP_W-1:0]  STEP_MAX_RST     = 26'd52428800;
   localparam logic [STEP_W-1:0]  STEP_MIN_RST     = 26'd1;
   localparam logic [STEP_W-1:0]  INITIAL_STEP_RST = 26'd104858;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_UPDATE = 2'd1,
      OP_READ   = 2'd2
   } rwu_op_type;

   typedef enum logic [1:0] {
      SC_ZERO     = 2'd0,
      SC_RETAINED = 2'd1,
      SC_FLIPPED  = 2'd2,
      SC_NONE     = 2'd3
   } rwu_case_type;

   typedef enum logic [1:0] {
      SIGN_ZERO = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } rwu_sign_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ETA_PLUS     = 3'd0,
      CSR_ETA_MINUS    = 3'd1,
      CSR_STEP_MAX     = 3'd2,
      CSR_STEP_MIN     = 3'd3,
      CSR_INITIAL_STEP = 3'd4
   } rwu_csr_type;

   typedef enum logic {
      MODE_CLEAR = 1'b0,
      MODE_RUN   = 1'b1
   } rwu_mode_type;

   typedef struct packed {
      logic [VALUE_W-1:0] last_change;
      logic [STEP_W-1:0]  step;
      logic               step_valid;
      logic [1:0]         last_sign;
   } rwu_state_type;

endpackage
`default_nettype wire

>>> rtl/rwu_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RPROP weight update unit - channel interfaces
// Request and response channels with valid/ready handshake and payload.
// ----------------------------------------------------------------------------
interface rwu_req_if;
   logic                                valid;
   logic                                ready;
   logic [1:0]                          opcode;
   logic [rwu_pkg::IDX_W-1:0]           weight_index;
   logic signed [rwu_pkg::VALUE_W-1:0]  gradient;
   logic signed [rwu_pkg::VALUE_W-1:0]  load_value;

   modport source (output valid, opcode, weight_index, gradient, load_value, input ready);
   modport sink   (input valid, opcode, weight_index, gradient, load_value, output ready);
endinterface

interface rwu_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [rwu_pkg::IDX_W-1:0]           result_index;
   logic signed [rwu_pkg::VALUE_W-1:0]  weight_value;
   logic signed [rwu_pkg::VALUE_W-1:0]  applied_change;
   logic [1:0]                          sign_case;
   logic                                saturated;

   modport source (output valid, result_index, weight_value, applied_change, sign_case,
                   saturated, input ready);
   modport sink   (input valid, result_index, weight_value, applied_change, sign_case,
                   saturated, output ready);
endinterface
`default_nettype wire

>>> rtl/rwu_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RPROP weight update unit - generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rwu_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> rtl/rprop_weight_update_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// RPROP weight update unit - top level
// Per-weight RPROP+ update with backtracking: weight and adaptation state
// held in two synchronous RAMs, read-modify-write over a short pipeline.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item is registered in stage 1, then stage 2, then the result register.
// Throughput: one item per cycle while the response channel takes results; an item to the same
//   entry as a writing item in stage 1, or in a stalled stage 2, waits until that item writes back.
// Reset: configuration registers take their reset values; the state RAM is then
//   cleared one entry a cycle, entry 0 up to NUM_WEIGHTS-1, and no item is accepted meanwhile.
// ----------------------------------------------------------------------------
module rprop_weight_update_unit #(
   parameter int unsigned NUM_WEIGHTS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   rwu_req_if.sink                         req_chan,
   rwu_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [rwu_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [rwu_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int unsigned AW    = $clog2(NUM_WEIGHTS);
   localparam int unsigned EXT_W = 17;
   localparam int unsigned VW    = rwu_pkg::VALUE_W;
   localparam int unsigned SW    = rwu_pkg::STEP_W;
   localparam int unsigned WW    = rwu_pkg::WIDE_W;
   localparam int unsigned ST_W  = $bits(rwu_pkg::rwu_state_type);

   // configuration registers
   logic [rwu_pkg::ETA_W-1:0]   eta_plus_ff,     eta_plus_in;
   logic [rwu_pkg::ETA_M_W-1:0] eta_minus_ff,    eta_minus_in;
   logic [SW-1:0]               step_max_ff,     step_max_in;
   logic [SW-1:0]               step_min_ff,     step_min_in;
   logic [SW-1:0]               initial_step_ff, initial_step_in;

   always_comb begin
      eta_plus_in     = eta_plus_ff;
      eta_minus_in    = eta_minus_ff;
      step_max_in     = step_max_ff;
      step_min_in     = step_min_ff;
      initial_step_in = initial_step_ff;
      if (csr_we) begin
         case (csr_index)
            rwu_pkg::CSR_ETA_PLUS:     eta_plus_in     = csr_wdata[rwu_pkg::ETA_W-1:0];
            rwu_pkg::CSR_ETA_MINUS:    eta_minus_in    = csr_wdata[rwu_pkg::ETA_M_W-1:0];
            rwu_pkg::CSR_STEP_MAX:     step_max_in     = csr_wdata[SW-1:0];
            rwu_pkg::CSR_STEP_MIN:     step_min_in     = csr_wdata[SW-1:0];
            rwu_pkg::CSR_INITIAL_STEP: initial_step_in = csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eta_plus_ff     <= rwu_pkg::ETA_PLUS_RST;
         eta_minus_ff    <= rwu_pkg::ETA_MINUS_RST;
         step_max_ff     <= rwu_pkg::STEP_MAX_RST;
         step_min_ff     <= rwu_pkg::STEP_MIN_RST;
         initial_step_ff <= rwu_pkg::INITIAL_STEP_RST;
      end else begin
         eta_plus_ff     <= eta_plus_in;
         eta_minus_ff    <= eta_minus_in;
         step_max_ff     <= step_max_in;
         step_min_ff     <= step_min_in;
         initial_step_ff <= initial_step_in;
      end
   end

   // state RAM clearing sequencer
   rwu_pkg::rwu_mode_type mode_ff, mode_in;
   logic [AW-1:0]         clr_cnt_ff, clr_cnt_in;
   logic                  clr_we;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= rwu_pkg::MODE_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         mode_ff    <= mode_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_comb begin
      mode_in    = mode_ff;
      clr_cnt_in = clr_cnt_ff;
      clr_we     = 1'b0;
      case (mode_ff)
         rwu_pkg::MODE_CLEAR: begin
            clr_we     = 1'b1;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == AW'(NUM_WEIGHTS - 1)) begin
               mode_in = rwu_pkg::MODE_RUN;
            end
         end
         rwu_pkg::MODE_RUN: ;
         default: mode_in = rwu_pkg::MODE_CLEAR;
      endcase
   end

   // pipeline registers
   logic                              s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic [1:0]                        s1_op_ff, s2_op_ff;
   logic [rwu_pkg::IDX_W-1:0]         s1_idx_ff, s2_idx_ff;
   logic [AW-1:0]                     s1_entry_ff, s2_entry_ff;
   logic signed [VW-1:0]              s1_grad_ff;
   logic signed [VW-1:0]              s1_load_ff, s2_load_ff;
   logic                              s1_fw_w_hit_ff, s1_fw_s_hit_ff;
   logic [VW-1:0]                     s1_fw_w_ff;
   rwu_pkg::rwu_state_type            s1_fw_s_ff;
   rwu_pkg::rwu_case_type             s2_case_ff;
   logic                              s2_gpos_ff, s2_gneg_ff;
   logic [SW-1:0]                     s2_step_ff;
   logic [rwu_pkg::PROD_W-1:0]        s2_prod_ff;
   logic [VW-1:0]                     s2_w_ff;
   rwu_pkg::rwu_state_type            s2_st_ff;
   logic [rwu_pkg::IDX_W-1:0]         rsp_idx_ff;
   logic [VW-1:0]                     rsp_weight_ff, rsp_change_ff;
   logic [1:0]                        rsp_case_ff;
   logic                              rsp_sat_ff;

   logic adv1, adv2, adv3;
   logic accept;
   logic s1_writes, s2_writes, hazard;
   logic [EXT_W-1:0] req_idx_ext;
   logic [AW-1:0]    req_entry;

   // write-back from the second stage
   logic                   wb_w_en, wb_s_en;
   logic [VW-1:0]          wb_w_data;
   rwu_pkg::rwu_state_type wb_s_data;

   assign adv3 = !rsp_valid_ff || rsp_chan.ready;
   assign adv2 = !s2_valid_ff || adv3;
   assign adv1 = !s1_valid_ff || adv2;

   assign req_idx_ext = EXT_W'(req_chan.weight_index);
   assign req_entry   = AW'(req_idx_ext % NUM_WEIGHTS);

   assign s1_writes = s1_valid_ff &&
                      (s1_op_ff == rwu_pkg::OP_LOAD || s1_op_ff == rwu_pkg::OP_UPDATE);
   assign s2_writes = s2_valid_ff &&
                      (s2_op_ff == rwu_pkg::OP_LOAD || s2_op_ff == rwu_pkg::OP_UPDATE);
   assign hazard    = (s1_writes && s1_entry_ff == req_entry) ||
                      (s2_writes && !adv3 && s2_entry_ff == req_entry);

   assign req_chan.ready = (mode_ff == rwu_pkg::MODE_RUN) && adv1 && !hazard;
   assign accept         = req_chan.valid && req_chan.ready;

   // RAMs
   logic [VW-1:0]          w_rd_data;
   logic [ST_W-1:0]        st_rd_bits;
   logic                   st_we;
   logic [AW-1:0]          st_waddr;
   logic [ST_W-1:0]        st_wdata;

   assign st_we    = clr_we || wb_s_en;
   assign st_waddr = clr_we ? clr_cnt_ff : s2_entry_ff;
   assign st_wdata = clr_we ? '0 : wb_s_data;

   rwu_ram #(.WIDTH(VW), .DEPTH(NUM_WEIGHTS)) u_weight_ram (
      .clock   (clock),
      .wr_en   (wb_w_en),
      .wr_addr (s2_entry_ff),
      .wr_data (wb_w_data),
      .rd_en   (accept),
      .rd_addr (req_entry),
      .rd_data (w_rd_data)
   );

   rwu_ram #(.WIDTH(ST_W), .DEPTH(NUM_WEIGHTS)) u_state_ram (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_addr (st_waddr),
      .wr_data (st_wdata),
      .rd_en   (accept),
      .rd_addr (req_entry),
      .rd_data (st_rd_bits)
   );

   // stage 1 inputs: capture item and any write landing on the same edge
   logic                   s1_valid_in;
   logic                   s1_fw_w_hit_in, s1_fw_s_hit_in;

   assign s1_valid_in    = accept;
   assign s1_fw_w_hit_in = wb_w_en && s2_entry_ff == req_entry;
   assign s1_fw_s_hit_in = wb_s_en && s2_entry_ff == req_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv1) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff       <= req_chan.opcode;
         s1_idx_ff      <= req_chan.weight_index;
         s1_entry_ff    <= req_entry;
         s1_grad_ff     <= req_chan.gradient;
         s1_load_ff     <= req_chan.load_value;
         s1_fw_w_hit_ff <= s1_fw_w_hit_in;
         s1_fw_s_hit_ff <= s1_fw_s_hit_in;
         s1_fw_w_ff     <= wb_w_data;
         s1_fw_s_ff     <= wb_s_data;
      end
   end

   // stage 1: merge, classify, scale step
   logic [VW-1:0]              w_cur;
   rwu_pkg::rwu_state_type     st_cur;
   logic                       g_pos, g_neg, ls_pos, ls_neg, retained, flipped;
   logic [SW-1:0]              step_cur;
   logic [rwu_pkg::ETA_W-1:0]  eta_sel;
   logic [rwu_pkg::PROD_W-1:0] prod_in;
   rwu_pkg::rwu_case_type      case_in;

   always_comb begin
      w_cur    = s1_fw_w_hit_ff ? s1_fw_w_ff : w_rd_data;
      st_cur   = s1_fw_s_hit_ff ? s1_fw_s_ff : rwu_pkg::rwu_state_type'(st_rd_bits);
      g_neg    = s1_grad_ff[VW-1];
      g_pos    = !s1_grad_ff[VW-1] && (|s1_grad_ff);
      ls_pos   = st_cur.last_sign == rwu_pkg::SIGN_POS;
      ls_neg   = st_cur.last_sign == rwu_pkg::SIGN_NEG;
      retained = (g_pos && ls_pos) || (g_neg && ls_neg);
      flipped  = (g_pos && ls_neg) || (g_neg && ls_pos);
      step_cur = st_cur.step_valid ? st_cur.step : initial_step_ff;
      eta_sel  = retained ? eta_plus_ff : rwu_pkg::ETA_W'(eta_minus_ff);
      prod_in  = rwu_pkg::PROD_W'(step_cur) * rwu_pkg::PROD_W'(eta_sel);
      if (s1_op_ff != rwu_pkg::OP_UPDATE) begin
         case_in = rwu_pkg::SC_NONE;
      end else if (retained) begin
         case_in = rwu_pkg::SC_RETAINED;
      end else if (flipped) begin
         case_in = rwu_pkg::SC_FLIPPED;
      end else begin
         case_in = rwu_pkg::SC_ZERO;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv2 && s1_valid_ff) begin
         s2_op_ff    <= s1_op_ff;
         s2_idx_ff   <= s1_idx_ff;
         s2_entry_ff <= s1_entry_ff;
         s2_load_ff  <= s1_load_ff;
         s2_case_ff  <= case_in;
         s2_gpos_ff  <= g_pos;
         s2_gneg_ff  <= g_neg;
         s2_step_ff  <= step_cur;
         s2_prod_ff  <= prod_in;
         s2_w_ff     <= w_cur;
         s2_st_ff    <= st_cur;
      end
   end

   // stage 2: round, bound, apply change, saturate
   logic [rwu_pkg::PROD_W:0]     round_sum;
   logic [rwu_pkg::SCALED_W-1:0] scaled;
   logic [SW-1:0]                step_clip, new_step, mag;
   logic signed [WW-1:0]         mag_ext, change, diff;
   logic                         ovf;
   logic [VW-1:0]                upd_weight;
   logic [VW-1:0]                rsp_weight_in, rsp_change_in;
   logic                         rsp_sat_in;
   logic [1:0]                   sg_code;

   always_comb begin
      round_sum = {1'b0, s2_prod_ff} + rwu_pkg::ROUND_ADD;
      scaled    = round_sum[rwu_pkg::PROD_W:rwu_pkg::FRAC_SHIFT];
      step_clip = (|scaled[rwu_pkg::SCALED_W-1:SW]) ? '1 : scaled[SW-1:0];
      if (s2_case_ff == rwu_pkg::SC_RETAINED) begin
         new_step = (step_clip > step_max_ff) ? step_max_ff : step_clip;
      end else begin
         new_step = (step_clip < step_min_ff) ? step_min_ff : step_clip;
      end
      mag     = (s2_case_ff == rwu_pkg::SC_RETAINED) ? new_step : s2_step_ff;
      mag_ext = WW'(mag);
      sg_code = s2_gpos_ff ? rwu_pkg::SIGN_POS :
                (s2_gneg_ff ? rwu_pkg::SIGN_NEG : rwu_pkg::SIGN_ZERO);

      case (s2_case_ff)
         rwu_pkg::SC_ZERO, rwu_pkg::SC_RETAINED: begin
            change = s2_gpos_ff ? mag_ext : (s2_gneg_ff ? -mag_ext : '0);
         end
         rwu_pkg::SC_FLIPPED: change = -WW'(signed'(s2_st_ff.last_change));
         default:             change = '0;
      endcase

      diff       = WW'(signed'(s2_w_ff)) - change;
      ovf        = !(diff[WW-1:VW-1] == '0 || diff[WW-1:VW-1] == '1);
      upd_weight = ovf ? (diff[WW-1] ? {1'b1, {(VW-1){1'b0}}} : {1'b0, {(VW-1){1'b1}}})
                       : diff[VW-1:0];

      wb_s_data = s2_st_ff;
      case (s2_case_ff)
         rwu_pkg::SC_ZERO: wb_s_data.last_sign = sg_code;
         rwu_pkg::SC_RETAINED: begin
            wb_s_data.last_sign   = sg_code;
            wb_s_data.step        = new_step;
            wb_s_data.step_valid  = 1'b1;
            wb_s_data.last_change = change[VW-1:0];
         end
         rwu_pkg::SC_FLIPPED: begin
            wb_s_data.last_sign  = rwu_pkg::SIGN_ZERO;
            wb_s_data.step       = new_step;
            wb_s_data.step_valid = 1'b1;
         end
         default: ;
      endcase

      case (s2_op_ff)
         rwu_pkg::OP_LOAD: begin
            rsp_weight_in = s2_load_ff;
            rsp_change_in = '0;
            rsp_sat_in    = 1'b0;
         end
         rwu_pkg::OP_UPDATE: begin
            rsp_weight_in = upd_weight;
            rsp_change_in = change[VW-1:0];
            rsp_sat_in    = ovf;
         end
         default: begin
            rsp_weight_in = s2_w_ff;
            rsp_change_in = '0;
            rsp_sat_in    = 1'b0;
         end
      endcase

      wb_w_data = rsp_weight_in;
      wb_w_en   = s2_writes && adv3;
      wb_s_en   = s2_valid_ff && adv3 && s2_op_ff == rwu_pkg::OP_UPDATE;
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv3 && s2_valid_ff) begin
         rsp_idx_ff    <= s2_idx_ff;
         rsp_weight_ff <= rsp_weight_in;
         rsp_change_ff <= rsp_change_in;
         rsp_case_ff   <= s2_case_ff;
         rsp_sat_ff    <= rsp_sat_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.result_index   = rsp_idx_ff;
   assign rsp_chan.weight_value   = rsp_weight_ff;
   assign rsp_chan.applied_change = rsp_change_ff;
   assign rsp_chan.sign_case      = rsp_case_ff;
   assign rsp_chan.saturated      = rsp_sat_ff;

   // checks
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> (mode_ff == rwu_pkg::MODE_RUN))
      else $error("item accepted during state clear");

   a_no_same_entry_in_flight: assert property (@(posedge clock) disable iff (reset)
      (s1_writes && s2_writes) |-> (s1_entry_ff != s2_entry_ff))
      else $error("two writers to one entry in the pipeline");

   a_no_change_without_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_case_ff == rwu_pkg::SC_NONE) |-> (rsp_change_ff == '0))
      else $error("change reported for a non-update item");

   a_no_pipe_during_clear: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == rwu_pkg::MODE_CLEAR) |-> !(s1_valid_ff || s2_valid_ff))
      else $error("pipeline busy while clearing state");

endmodule
`default_nettype wire

>>> verif/tb_rprop_weight_update_unit.sv
// ----------------------------------------------------------------------------
// RPROP weight update unit - testbench
// Loads, reads and updates weights through the request channel with random
// gaps and response stalls. A local copy of the per-entry state works out each
// expected response, and the responses are checked field by field in order.
// The run covers directed sign cases and saturation, several rate settings
// including the extremes, a long response stall, and random traffic.
// ----------------------------------------------------------------------------
module tb_rprop_weight_update_unit;
   import rwu_pkg::*;

   localparam int unsigned ENTRIES     = 1024;
   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam logic [1:0]  OP_SPARE    = 2'd3;

   typedef struct {
      logic [IDX_W-1:0]   index;
      logic [VALUE_W-1:0] weight;
      logic [VALUE_W-1:0] change;
      rwu_case_type       sign_case;
      logic               saturated;
   } weight_result_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   rwu_req_if req_chan ();
   rwu_rsp_if rsp_chan ();

   rprop_weight_update_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // rate settings as currently programmed
   logic [ETA_W-1:0]   cfg_eta_plus     = ETA_PLUS_RST;
   logic [ETA_M_W-1:0] cfg_eta_minus    = ETA_MINUS_RST;
   logic [STEP_W-1:0]  cfg_step_max     = STEP_MAX_RST;
   logic [STEP_W-1:0]  cfg_step_min     = STEP_MIN_RST;
   logic [STEP_W-1:0]  cfg_initial_step = INITIAL_STEP_RST;

   // per-entry state
   bit [VALUE_W-1:0] weight_mem [ENTRIES];
   bit [1:0]         sign_mem   [ENTRIES];
   bit [STEP_W-1:0]  step_mem   [ENTRIES];
   bit               step_held  [ENTRIES];
   bit [VALUE_W-1:0] change_mem [ENTRIES];

   bit loaded    [ENTRIES];
   bit trend_neg [ENTRIES];

   weight_result_type weight_results_due[$];

   int unsigned mismatches   = 0;
   int unsigned cycle_count  = 0;
   int unsigned stall_burst  = 0;
   bit          sender_quiet = 1'b0;
   bit          drain_quiet  = 1'b0;

   function automatic int unsigned draw_gap(input bit quiet);
      if (quiet) return 0;
      return $urandom_range(0, 17);
   endfunction

   function automatic logic [STEP_W-1:0] scale_step(input logic [STEP_W-1:0] step,
                                                    input logic [ETA_W-1:0] eta);
      logic [PROD_W:0] prod;
      prod = ({{(ETA_W + 1){1'b0}}, step} * {{(STEP_W + 1){1'b0}}, eta}) + ROUND_ADD;
      prod = prod >> FRAC_SHIFT;
      if (|prod[PROD_W:STEP_W]) return {STEP_W{1'b1}};
      return prod[STEP_W-1:0];
   endfunction

   function automatic logic [VALUE_W-1:0] signed_step(input rwu_sign_type s,
                                                      input logic [STEP_W-1:0] mag);
      logic [VALUE_W-1:0] wide;
      wide = {{(VALUE_W - STEP_W){1'b0}}, mag};
      case (s)
         SIGN_POS: return wide;
         SIGN_NEG: return -wide;
         default:  return '0;
      endcase
   endfunction

   task automatic compute_weight_result(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                        input logic [VALUE_W-1:0] grad,
                                        input logic [VALUE_W-1:0] val);
      weight_result_type  res;
      rwu_sign_type       gsign;
      logic [STEP_W-1:0]  step;
      logic [VALUE_W+1:0] diff;
      res.index     = idx;
      res.change    = '0;
      res.sign_case = SC_NONE;
      res.saturated = 1'b0;
      if (op == OP_LOAD) begin
         weight_mem[idx] = val;
      end else if (op == OP_UPDATE) begin
         if (grad[VALUE_W-1]) gsign = SIGN_NEG;
         else if (grad != '0) gsign = SIGN_POS;
         else gsign = SIGN_ZERO;
         step = step_held[idx] ? step_mem[idx] : cfg_initial_step;
         if (gsign == SIGN_ZERO || sign_mem[idx] == SIGN_ZERO) begin
            res.change    = signed_step(gsign, step);
            res.sign_case = SC_ZERO;
            sign_mem[idx] = gsign;
         end else if (gsign == sign_mem[idx]) begin
            step = scale_step(step, cfg_eta_plus);
            if (step > cfg_step_max) step = cfg_step_max;
            res.change      = signed_step(gsign, step);
            res.sign_case   = SC_RETAINED;
            step_mem[idx]   = step;
            step_held[idx]  = 1'b1;
            sign_mem[idx]   = gsign;
            change_mem[idx] = res.change;
         end else begin
            step = scale_step(step, {1'b0, cfg_eta_minus});
            if (step < cfg_step_min) step = cfg_step_min;
            // undo the last change
            res.change     = -change_mem[idx];
            res.sign_case  = SC_FLIPPED;
            step_mem[idx]  = step;
            step_held[idx] = 1'b1;
            sign_mem[idx]  = SIGN_ZERO;
         end
         diff = {{2{weight_mem[idx][VALUE_W-1]}}, weight_mem[idx]}
              - {{2{res.change[VALUE_W-1]}}, res.change};
         if (&diff[VALUE_W+1:VALUE_W-1] || ~|diff[VALUE_W+1:VALUE_W-1]) begin
            weight_mem[idx] = diff[VALUE_W-1:0];
         end else begin
            res.saturated   = 1'b1;
            weight_mem[idx] = diff[VALUE_W+1] ? {1'b1, {(VALUE_W - 1){1'b0}}}
                                              : {1'b0, {(VALUE_W - 1){1'b1}}};
         end
      end
      res.weight = weight_mem[idx];
      weight_results_due.push_back(res);
   endtask

   task automatic send_item(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                            input logic [VALUE_W-1:0] grad, input logic [VALUE_W-1:0] val);
      int unsigned gap;
      gap = draw_gap(sender_quiet);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.opcode       <= op;
      req_chan.weight_index <= idx;
      req_chan.gradient     <= grad;
      req_chan.load_value   <= val;
      do @(posedge clock); while (!req_chan.ready);
      compute_weight_result(op, idx, grad, val);
      if (op == OP_LOAD) loaded[idx] = 1'b1;
   endtask

   task automatic send_random_item(input logic [IDX_W-1:0] hot_base);
      int unsigned        pick;
      logic [1:0]         op;
      logic [IDX_W-1:0]   idx;
      logic [VALUE_W-1:0] grad;
      logic [VALUE_W-1:0] val;
      bit                 neg;
      pick = $urandom_range(0, 99);
      if (pick < 10) op = OP_LOAD;
      else if (pick < 78) op = OP_UPDATE;
      else if (pick < 94) op = OP_READ;
      else op = OP_SPARE;
      if ($urandom_range(0, 3) == 0) idx = IDX_W'($urandom_range(0, ENTRIES - 1));
      else idx = hot_base + IDX_W'($urandom_range(0, 7));
      // never touch an entry whose weight was not loaded
      if (op != OP_LOAD && !loaded[idx]) op = OP_LOAD;
      grad = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         grad = '0;
      end else begin
         neg = (pick < 78) ? trend_neg[idx] : !trend_neg[idx];
         grad[VALUE_W-1] = neg;
         trend_neg[idx] = neg;
      end
      val = $urandom;
      if ($urandom_range(0, 1)) val = {{8{val[23]}}, val[23:0]};
      send_item(op, idx, grad, val);
   endtask

   task automatic run_random_block(input int unsigned count);
      logic [IDX_W-1:0] hot_base;
      hot_base = IDX_W'($urandom_range(0, ENTRIES - 8));
      repeat (count) send_random_item(hot_base);
   endtask

   task automatic settle(input int unsigned tail);
      req_chan.valid <= 1'b0;
      while (weight_results_due.size() != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   task automatic csr_write(input rwu_csr_type idx, input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_rates(input logic [ETA_W-1:0] eta_p, input logic [ETA_M_W-1:0] eta_m,
                                input logic [STEP_W-1:0] s_max, input logic [STEP_W-1:0] s_min,
                                input logic [STEP_W-1:0] s_init);
      csr_write(CSR_ETA_PLUS, CSR_DATA_W'(eta_p));
      csr_write(CSR_ETA_MINUS, CSR_DATA_W'(eta_m));
      csr_write(CSR_STEP_MAX, s_max);
      csr_write(CSR_STEP_MIN, s_min);
      csr_write(CSR_INITIAL_STEP, s_init);
      csr_we           <= 1'b0;
      cfg_eta_plus     = eta_p;
      cfg_eta_minus    = eta_m;
      cfg_step_max     = s_max;
      cfg_step_min     = s_min;
      cfg_initial_step = s_init;
   endtask

   task automatic test_load_and_read();
      send_item(OP_LOAD, 10'd0, 32'h0000_0000, 32'h7FFF_FFFF);
      send_item(OP_LOAD, 10'd1023, 32'hFFFF_FFFF, 32'h8000_0000);
      send_item(OP_LOAD, 10'd5, 32'h0000_0000, 32'h0010_0000);
      send_item(OP_LOAD, 10'd512, 32'h7FFF_FFFF, 32'h0000_0000);
      send_item(OP_READ, 10'd512, 32'h0000_0000, 32'hFFFF_FFFF);
      send_item(OP_SPARE, 10'd1023, 32'h0000_0000, 32'h0000_0000);
   endtask

   task automatic test_sign_cases();
      // zero, first positive, two retained, flip, then rebuild the sign
      send_item(OP_UPDATE, 10'd5, 32'h0000_0000, 32'h0);
      send_item(OP_UPDATE, 10'd5, 32'h0010_0000, 32'h0);
      send_item(OP_UPDATE, 10'd5, 32'h0008_0000, 32'h0);
      send_item(OP_UPDATE, 10'd5, 32'h7FFF_FFFF, 32'h0);
      send_item(OP_UPDATE, 10'd5, 32'h8000_0000, 32'h0);
      send_item(OP_UPDATE, 10'd5, 32'hFFFF_FFFF, 32'h0);
      send_item(OP_UPDATE, 10'd5, 32'hFFF0_0000, 32'h0);
      send_item(OP_UPDATE, 10'd5, 32'h0000_0000, 32'h0);
      // push the extreme weights past their range
      send_item(OP_UPDATE, 10'd0, 32'hFFF0_0000, 32'h0);
      send_item(OP_UPDATE, 10'd1023, 32'h0010_0000, 32'h0);
      send_item(OP_READ, 10'd0, 32'h0, 32'h0);
      send_item(OP_READ, 10'd5, 32'h0, 32'h0);
   endtask

   task automatic test_rate_settings();
      settle(4);
      program_rates({ETA_W{1'b1}}, 15'd16384, {STEP_W{1'b1}}, 26'd1, {STEP_W{1'b1}});
      run_random_block(150);
      settle(4);
      program_rates('0, '0, 26'd1, {STEP_W{1'b1}}, 26'd1);
      run_random_block(150);
      settle(4);
      program_rates(ETA_W'($urandom_range(0, 65535)), ETA_M_W'($urandom_range(0, 16384)),
                    STEP_W'($urandom_range(1, 67108863)), STEP_W'($urandom_range(1, 1 << 20)),
                    STEP_W'($urandom_range(1, 1 << 22)));
      run_random_block(150);
      settle(4);
      program_rates(ETA_PLUS_RST, ETA_MINUS_RST, STEP_MAX_RST, STEP_MIN_RST, INITIAL_STEP_RST);
      run_random_block(150);
   endtask

   task automatic test_output_backpressure();
      sender_quiet = 1'b1;
      stall_burst  = 300;
      run_random_block(80);
      sender_quiet = 1'b0;
   endtask

   task automatic test_random_traffic();
      repeat (10) begin
         sender_quiet = ($urandom_range(0, 3) == 0);
         drain_quiet  = ($urandom_range(0, 3) == 0);
         run_random_block(75);
      end
      sender_quiet = 1'b0;
      drain_quiet  = 1'b0;
   endtask

   function automatic void check_field(input string name, input logic [VALUE_W-1:0] want,
                                       input logic [VALUE_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      weight_result_type due;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (weight_results_due.size() == 0) begin
            $display("%0t: result for entry %0d with none expected", $time,
                     rsp_chan.result_index);
            mismatches++;
         end else begin
            due = weight_results_due.pop_front();
            check_field("result_index", due.index, rsp_chan.result_index);
            check_field("weight_value", due.weight, rsp_chan.weight_value);
            check_field("applied_change", due.change, rsp_chan.applied_change);
            check_field("sign_case", due.sign_case, rsp_chan.sign_case);
            check_field("saturated", due.saturated, rsp_chan.saturated);
         end
      end
   end

   initial begin : rsp_drain
      int unsigned hold;
      rsp_chan.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (stall_burst > 0) begin
            hold        = stall_burst;
            stall_burst = 0;
         end else begin
            hold = draw_gap(drain_quiet);
         end
         if (hold > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_chan.valid && rsp_chan.ready));
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin : sequencer
      reset                 <= 1'b1;
      csr_we                <= 1'b0;
      csr_index             <= CSR_ETA_PLUS;
      csr_wdata             <= '0;
      req_chan.valid        <= 1'b0;
      req_chan.opcode       <= OP_READ;
      req_chan.weight_index <= '0;
      req_chan.gradient     <= '0;
      req_chan.load_value   <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_load_and_read();
      test_sign_cases();
      test_rate_settings();
      test_output_backpressure();
      test_random_traffic();
      settle(16);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/rwu_pkg.sv
rtl/rwu_if.sv
rtl/rwu_ram.sv
rtl/rprop_weight_update_unit.sv
verif/tb_rprop_weight_update_unit.sv
